// ----- hw/rtl/mss_pkg.sv -----
// Shared types and constants of the motion script sequencer.
package mss_pkg;

    // input operations
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_STEP   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // stored command codes
    localparam logic [2:0] C_STA = 3'd1;
    localparam logic [2:0] C_END = 3'd2;
    localparam logic [2:0] C_MOV = 3'd3;
    localparam logic [2:0] C_DEY = 3'd4;
    localparam logic [2:0] C_CMG = 3'd5;
    localparam logic [2:0] C_JMP = 3'd6;

    // player states as reported
    localparam logic [1:0] ST_STANDBY = 2'd0;
    localparam logic [1:0] ST_PLAYING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_STOPPED = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS       = 2'd1;

    localparam int unsigned CD_W = 26;
    localparam logic [CD_W-1:0] CD_MAX = {CD_W{1'b1}};

    localparam logic [9:0]  RETRIGGER_RESET = 10'd10;
    localparam logic [15:0] TPS_RESET       = 16'd1000;

    typedef struct packed {
        logic [2:0]         code;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ----- hw/rtl/mss_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module mss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/motion_script_sequencer_unit.sv -----
// Motion script sequencer: program store, command interpreter and tick trigger.
// Each request gives one registered result, but a MOV group gives one motion result per
// entry of the group, the last one marked; a tick that does not fire gives nothing.
// One request at a time: the next is taken the cycle after the last result is registered.
// Reset: synchronous; program empty, pointer zero, standby, trigger disarmed, store as is.
module motion_script_sequencer_unit
    import mss_pkg::*;
#(
    parameter int unsigned PROGRAM_DEPTH = 256,
    parameter int unsigned GROUP_LIMIT   = 63
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_op,
    input  logic [2:0]                         i_entry_code,
    input  logic signed [15:0]                 i_arg_a,
    input  logic signed [15:0]                 i_arg_b,
    input  logic signed [15:0]                 i_arg_c,

    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_kind,
    output logic signed [15:0]                 o_motion_a,
    output logic signed [15:0]                 o_motion_b,
    output logic signed [15:0]                 o_motion_c,
    output logic [1:0]                         o_player_state,
    output logic [$clog2(PROGRAM_DEPTH+1)-1:0] o_next_index,
    output logic                               o_last,

    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
    localparam int unsigned PW = $clog2(PROGRAM_DEPTH + 1);
    localparam int unsigned GW = $clog2(GROUP_LIMIT + 1);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);
    localparam logic [PW-1:0] PTR_DEPTH = PW'(PROGRAM_DEPTH);
    localparam logic [15:0]   DEPTH16   = 16'(PROGRAM_DEPTH);
    localparam logic [15:0]   GLIM16    = 16'(GROUP_LIMIT);
    localparam logic [GW-1:0] GRP_LIMIT = GW'(GROUP_LIMIT);
    localparam logic [GW-1:0] GRP_ONE   = GW'(1);
    localparam logic [CD_W-1:0] CD_ONE  = CD_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,      // issue the read of the entry under the pointer
        S_FETCH,     // entry arrives: interpret it
        S_MUL,       // DEY: seconds times ticks per second
        S_SCHED,     // DEY: saturate and arm the trigger
        S_SCAN,      // MOV group: issue the read of the next candidate
        S_SCAN_CHK,  // MOV group: candidate arrives
        S_SCAN_END,  // MOV group: pointer and state settled
        S_EREAD,     // group emission: read entry
        S_EOUT,      // group emission: hand the motion result over
        S_REPORT     // hand one status report over
    } t_state;

    t_state             r_state;

    // architectural state
    logic [PW-1:0]      r_count;
    logic [PW-1:0]      r_ptr;
    logic [GW-1:0]      r_grp;
    logic [1:0]         r_run;
    logic [CD_W-1:0]    r_cd;
    logic               r_armed;
    logic [9:0]         r_retrigger;
    logic [15:0]        r_tps;

    // working registers of one step
    logic [PW-1:0]      r_base;
    logic [PW-1:0]      r_scan;
    logic [PW-1:0]      r_emit;
    logic [14:0]        r_sec;
    logic [30:0]        r_prod;

    // output register
    logic               r_out_valid;
    logic               r_out_kind;
    logic signed [15:0] r_out_a;
    logic signed [15:0] r_out_b;
    logic signed [15:0] r_out_c;
    logic [1:0]         r_out_state;
    logic [PW-1:0]      r_out_next;
    logic               r_out_last;

    logic               in_acc;
    logic               can_load;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             ent;
    t_entry             wr_ent;

    assign in_acc   = i_in_valid && !o_in_stall;
    // the output register frees up when empty or when its result is taken this cycle
    assign can_load = !r_out_valid || !i_out_stall;

    // Store accesses are serialised by the sequencer: writes only from idle, and read data
    // is used only while a step runs, so no step ever sees an entry that is being written.
    assign ram_we = in_acc && (i_op == OP_APPEND) && (r_count < PTR_DEPTH);
    assign wr_ent = '{code: i_entry_code, a: i_arg_a, b: i_arg_b, c: i_arg_c};

    always_comb begin
        unique case (r_state)
            S_SCAN, S_SCAN_CHK: ram_raddr = r_scan[AW-1:0];
            S_EREAD, S_EOUT:    ram_raddr = r_emit[AW-1:0];
            default:            ram_raddr = r_ptr[AW-1:0];
        endcase
    end

    mss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PROGRAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent = t_entry'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_grp       <= '0;
            r_run       <= ST_STANDBY;
            r_cd        <= '0;
            r_armed     <= 1'b0;
            r_retrigger <= RETRIGGER_RESET;
            r_tps       <= TPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // configuration must arrive only while idle (the block does not enforce it); take it at once
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RETRIGGER: r_retrigger <= i_cfg_data[9:0];
                    CFG_TPS:       r_tps       <= i_cfg_data;
                    default:       ;
                endcase
            end

            // drop the held result once taken; the result states reload it themselves
            if (r_out_valid && !i_out_stall && (r_state != S_EOUT) &&
                (r_state != S_REPORT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_op)
                            OP_CLEAR: begin
                                r_grp   <= '0;
                                r_ptr   <= '0;
                                r_count <= '0;
                                r_run   <= ST_STANDBY;
                                r_state <= S_REPORT;
                            end
                            OP_APPEND: begin
                                if (r_count < PTR_DEPTH) begin
                                    r_count <= r_count + PTR_ONE;
                                end
                                r_state <= S_REPORT;
                            end
                            OP_STEP: begin
                                r_state <= S_STEP;
                            end
                            OP_TICK: begin
                                // count down; fire at zero or one
                                if (r_armed) begin
                                    if (r_cd <= CD_ONE) begin
                                        r_cd    <= '0;
                                        r_armed <= 1'b0;
                                        r_state <= S_STEP;
                                    end else begin
                                        r_cd <= r_cd - CD_ONE;
                                    end
                                end
                            end
                            OP_STOP: begin
                                r_run   <= ST_STOPPED;
                                r_ptr   <= '0;
                                r_count <= '0;
                                r_state <= S_REPORT;
                            end
                            default: ;
                        endcase
                    end
                end

                S_STEP: begin
                    if (r_run == ST_STOPPED) begin
                        r_state <= S_REPORT;
                    end else if (r_ptr >= r_count) begin
                        // ran off the end of the program: halt
                        r_run   <= ST_STOPPED;
                        r_ptr   <= '0;
                        r_count <= '0;
                        r_state <= S_REPORT;
                    end else begin
                        r_run   <= ST_PLAYING;
                        r_state <= S_FETCH;
                    end
                end

                S_FETCH: begin
                    unique case (ent.code)
                        C_STA: begin
                            r_ptr   <= r_ptr + PTR_ONE;
                            r_cd    <= CD_W'(r_retrigger);
                            r_armed <= 1'b1;
                            r_state <= S_REPORT;
                        end
                        C_END: begin
                            r_ptr   <= r_ptr + PTR_ONE;
                            r_run   <= ST_STANDBY;
                            r_state <= S_REPORT;
                        end
                        C_MOV: begin
                            // the pointer settles once the group length is known
                            r_base  <= r_ptr;
                            r_scan  <= r_ptr + PTR_ONE;
                            if (r_grp != '0) begin
                                r_grp <= r_grp - GRP_ONE;
                            end
                            r_state <= S_SCAN;
                        end
                        C_DEY: begin
                            r_ptr   <= r_ptr + PTR_ONE;
                            r_sec   <= ent.a[15] ? 15'd0 : ent.a[14:0];
                            r_state <= S_MUL;
                        end
                        C_CMG: begin
                            r_ptr <= r_ptr + PTR_ONE;
                            if (ent.a[15]) begin
                                r_grp <= '0;
                            end else if (ent.a > $signed(GLIM16)) begin
                                r_grp <= GRP_LIMIT;
                            end else begin
                                r_grp <= ent.a[GW-1:0];
                            end
                            r_cd    <= CD_W'(r_retrigger);
                            r_armed <= 1'b1;
                            r_state <= S_REPORT;
                        end
                        C_JMP: begin
                            if (ent.a[15] || (16'(ent.a) > DEPTH16)) begin
                                r_ptr <= PTR_DEPTH;
                            end else begin
                                r_ptr <= ent.a[PW-1:0];
                            end
                            r_cd    <= CD_W'(r_retrigger);
                            r_armed <= 1'b1;
                            r_state <= S_REPORT;
                        end
                        default: begin
                            // unknown command halts the player
                            r_run   <= ST_STOPPED;
                            r_ptr   <= '0;
                            r_count <= '0;
                            r_state <= S_REPORT;
                        end
                    endcase
                end

                S_MUL: begin
                    r_prod  <= 31'(r_sec) * 31'(r_tps);
                    r_state <= S_SCHED;
                end

                S_SCHED: begin
                    r_cd    <= (r_prod[30:CD_W] != '0) ? CD_MAX : r_prod[CD_W-1:0];
                    r_armed <= 1'b1;
                    r_state <= S_REPORT;
                end

                S_SCAN: begin
                    if ((r_grp != '0) && (r_scan < r_count)) begin
                        r_state <= S_SCAN_CHK;
                    end else begin
                        r_state <= S_SCAN_END;
                    end
                end

                S_SCAN_CHK: begin
                    if (ent.code == C_MOV) begin
                        r_grp   <= r_grp - GRP_ONE;
                        r_scan  <= r_scan + PTR_ONE;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_SCAN_END;
                    end
                end

                S_SCAN_END: begin
                    r_ptr  <= r_scan;
                    r_run  <= ST_WAITING;
                    r_emit <= r_base;
                    // group cut short: retrigger to pick up the rest
                    if (r_grp != '0) begin
                        r_cd    <= CD_W'(r_retrigger);
                        r_armed <= 1'b1;
                    end
                    r_state <= S_EREAD;
                end

                S_EREAD: begin
                    r_state <= S_EOUT;
                end

                S_EOUT: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= 1'b1;
                        r_out_a     <= ent.a;
                        r_out_b     <= ent.b;
                        r_out_c     <= ent.c;
                        r_out_state <= r_run;
                        r_out_next  <= r_ptr;
                        r_out_last  <= ((r_emit + PTR_ONE) == r_ptr);
                        r_emit      <= r_emit + PTR_ONE;
                        r_state     <= ((r_emit + PTR_ONE) == r_ptr) ? S_IDLE : S_EREAD;
                    end
                end

                S_REPORT: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= 1'b0;
                        r_out_a     <= '0;
                        r_out_b     <= '0;
                        r_out_c     <= '0;
                        r_out_state <= r_run;
                        r_out_next  <= r_ptr;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_motion_a     = r_out_a;
    assign o_motion_b     = r_out_b;
    assign o_motion_c     = r_out_c;
    assign o_player_state = r_out_state;
    assign o_next_index   = r_out_next;
    assign o_last         = r_out_last;

endmodule
